### sv/allm_pkg.sv
// Shared types and constants of the array linked list manager.
package allm_pkg;

  localparam int unsigned CAPACITY = 255;
  localparam int unsigned NODES    = CAPACITY + 1;
  localparam int unsigned AW       = 8;
  localparam int unsigned DW       = 32;

  localparam logic [3:0] ACT_PUSH_BACK  = 4'd0;
  localparam logic [3:0] ACT_PUSH_FRONT = 4'd1;
  localparam logic [3:0] ACT_INS_AFTER  = 4'd2;
  localparam logic [3:0] ACT_INS_BEFORE = 4'd3;
  localparam logic [3:0] ACT_REMOVE     = 4'd4;
  localparam logic [3:0] ACT_FIND       = 4'd5;
  localparam logic [3:0] ACT_FRONT      = 4'd6;
  localparam logic [3:0] ACT_BACK       = 4'd7;
  localparam logic [3:0] ACT_NEXT       = 4'd8;
  localparam logic [3:0] ACT_PREV       = 4'd9;
  localparam logic [3:0] ACT_CLEAR      = 4'd10;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_UNLINKED = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef enum logic [3:0] {
    OP_INS_BACK,
    OP_INS_FRONT,
    OP_INS_AFTER,
    OP_INS_BEFORE,
    OP_REMOVE,
    OP_FIND,
    OP_FRONT,
    OP_BACK,
    OP_NEXT,
    OP_PREV,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e           op;
    logic [AW-1:0] pos;
    logic [DW-1:0] val;
    logic          bad_pos;
  } cmd_t;

endpackage

### sv/allm_front.sv
// Front end: decode and classify input transactions into a two-entry command queue.
module allm_front
  import allm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [3:0]    action_i,
  input  logic [AW-1:0] position_i,
  input  logic [DW-1:0] data_value_i,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  logic          cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       dec;
  logic       push;

  always_comb begin
    dec.pos     = position_i;
    dec.val     = data_value_i;
    dec.bad_pos = ({1'b0, position_i} > 9'(CAPACITY));
    unique case (action_i)
      ACT_PUSH_BACK:  dec.op = OP_INS_BACK;
      ACT_PUSH_FRONT: dec.op = OP_INS_FRONT;
      ACT_INS_AFTER:  dec.op = OP_INS_AFTER;
      ACT_INS_BEFORE: dec.op = OP_INS_BEFORE;
      ACT_REMOVE: begin
        dec.op      = OP_REMOVE;
        dec.bad_pos = dec.bad_pos | (position_i == '0);
      end
      ACT_FIND:       dec.op = OP_FIND;
      ACT_FRONT:      dec.op = OP_FRONT;
      ACT_BACK:       dec.op = OP_BACK;
      ACT_NEXT:       dec.op = OP_NEXT;
      ACT_PREV:       dec.op = OP_PREV;
      ACT_CLEAR:      dec.op = OP_CLEAR;
      default:        dec.op = OP_NOP;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i & ~in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule

### sv/allm_back.sv
// Back end: link tables, free stack and the sequencer that executes commands.
module allm_back
  import allm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cmd_t          cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    status_o,
  output logic [AW-1:0] node_address_o,
  output logic [DW-1:0] node_value_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_A, S_B, S_C, S_FIND, S_Q1, S_Q2
  } state_e;

  logic [AW-1:0] nxt_mem [NODES];
  logic [AW-1:0] prv_mem [NODES];
  logic [DW-1:0] val_mem [NODES];
  logic [AW-1:0] stk_mem [CAPACITY];

  logic          nxt_re, nxt_we, prv_re, prv_we, val_re, val_we, stk_re, stk_we;
  logic [AW-1:0] nxt_ra, nxt_wa, nxt_wd, prv_ra, prv_wa, prv_wd, stk_ra, stk_wa, stk_wd;
  logic [AW-1:0] val_ra, val_wa;
  logic [DW-1:0] val_wd;
  logic [AW-1:0] nxt_rd_q, prv_rd_q, stk_rd_q;
  logic [DW-1:0] val_rd_q;

  state_e        state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d, fc_q, fc_d, low_q, low_d;
  logic [AW-1:0] after_q, after_d, r_q, r_d, n_q, n_d;
  logic          after_rd_q, after_rd_d, r_rd_q, r_rd_d, n_rd_q, n_rd_d;
  logic          stk_const_q, stk_const_d;
  logic [NODES-1:0] linked_q, linked_d;
  logic          out_valid_q, out_valid_d;
  logic [2:0]    status_q, status_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [DW-1:0] value_q, value_d;

  logic [AW-1:0] fc_m1, a_sel, r_sel, n_sel;

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (nxt_re) nxt_rd_q <= nxt_mem[nxt_ra];
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (prv_re) prv_rd_q <= prv_mem[prv_ra];
    if (val_we) val_mem[val_wa] <= val_wd;
    if (val_re) val_rd_q <= val_mem[val_ra];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd_q <= stk_mem[stk_ra];
  end

  assign fc_m1 = fc_q - 1'b1;
  assign a_sel = after_rd_q ? prv_rd_q : after_q;
  assign r_sel = r_rd_q ? nxt_rd_q : r_q;
  assign n_sel = !n_rd_q ? n_q : ((cmd_q.op == OP_NEXT) ? nxt_rd_q : prv_rd_q);

  always_comb begin
    state_d = state_q;   cmd_d = cmd_q;   head_d = head_q; tail_d = tail_q;
    fc_d = fc_q;         low_d = low_q;   after_d = after_q; r_d = r_q; n_d = n_q;
    after_rd_d = after_rd_q; r_rd_d = r_rd_q; n_rd_d = n_rd_q;
    stk_const_d = stk_const_q; linked_d = linked_q;
    out_valid_d = out_valid_q & out_stall_i;
    status_d = status_q; addr_d = addr_q; value_d = value_q;
    cmd_pop_o = 1'b0;
    nxt_re = 1'b0; nxt_we = 1'b0; nxt_ra = '0; nxt_wa = '0; nxt_wd = '0;
    prv_re = 1'b0; prv_we = 1'b0; prv_ra = '0; prv_wa = '0; prv_wd = '0;
    val_re = 1'b0; val_we = 1'b0; val_ra = '0; val_wa = '0; val_wd = '0;
    stk_re = 1'b0; stk_we = 1'b0; stk_ra = '0; stk_wa = '0; stk_wd = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && (!out_valid_q || !out_stall_i)) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = S_CHK;
        end
      end
      S_CHK: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        status_d    = ST_OK;
        addr_d      = '0;
        value_d     = '0;
        case (cmd_q.op)
          OP_INS_BACK, OP_INS_FRONT, OP_INS_AFTER, OP_INS_BEFORE: begin
            if (cmd_q.bad_pos) begin
              status_d = ST_BADPOS;
            end else if ((cmd_q.op == OP_INS_AFTER || cmd_q.op == OP_INS_BEFORE) &&
                         !linked_q[cmd_q.pos]) begin
              status_d = ST_UNLINKED;
            end else if (fc_q == '0) begin
              status_d = ST_FULL;
            end else begin
              out_valid_d = out_valid_q & out_stall_i;
              state_d     = S_A;
              stk_re      = 1'b1;
              stk_ra      = fc_m1;
              stk_const_d = (fc_m1 < low_q);
              after_rd_d  = 1'b0;
              case (cmd_q.op)
                OP_INS_BACK:  after_d = tail_q;
                OP_INS_FRONT: after_d = '0;
                OP_INS_AFTER: after_d = cmd_q.pos;
                default: begin
                  if (cmd_q.pos == '0) begin
                    after_d = tail_q;
                  end else begin
                    prv_re     = 1'b1;
                    prv_ra     = cmd_q.pos;
                    after_rd_d = 1'b1;
                  end
                end
              endcase
            end
          end
          OP_REMOVE: begin
            if (cmd_q.bad_pos) begin
              status_d = ST_BADPOS;
            end else if (!linked_q[cmd_q.pos]) begin
              status_d = ST_UNLINKED;
            end else begin
              out_valid_d = out_valid_q & out_stall_i;
              state_d     = S_A;
              nxt_re = 1'b1; nxt_ra = cmd_q.pos;
              prv_re = 1'b1; prv_ra = cmd_q.pos;
            end
          end
          OP_FIND: begin
            if (head_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              out_valid_d = out_valid_q & out_stall_i;
              state_d     = S_FIND;
              n_d    = head_q;
              nxt_re = 1'b1; nxt_ra = head_q;
              val_re = 1'b1; val_ra = head_q;
            end
          end
          OP_FRONT, OP_BACK: begin
            out_valid_d = out_valid_q & out_stall_i;
            state_d     = S_Q1;
            n_rd_d      = 1'b0;
            n_d         = (cmd_q.op == OP_FRONT) ? head_q : tail_q;
          end
          OP_NEXT, OP_PREV: begin
            if (cmd_q.bad_pos) begin
              status_d = ST_BADPOS;
            end else if (!linked_q[cmd_q.pos]) begin
              status_d = ST_UNLINKED;
            end else begin
              out_valid_d = out_valid_q & out_stall_i;
              state_d     = S_Q1;
              if (cmd_q.pos == '0) begin
                n_rd_d = 1'b0;
                n_d    = (cmd_q.op == OP_NEXT) ? head_q : tail_q;
              end else begin
                n_rd_d = 1'b1;
                nxt_re = 1'b1; nxt_ra = cmd_q.pos;
                prv_re = 1'b1; prv_ra = cmd_q.pos;
              end
            end
          end
          OP_CLEAR: begin
            head_d   = '0;
            tail_d   = '0;
            fc_d     = AW'(CAPACITY);
            low_d    = AW'(CAPACITY);
            linked_d = NODES'(1);
          end
          default: ;
        endcase
      end
      S_A: begin
        if (cmd_q.op == OP_REMOVE) begin
          if (prv_rd_q == '0) begin
            head_d = nxt_rd_q;
          end else begin
            nxt_we = 1'b1; nxt_wa = prv_rd_q; nxt_wd = nxt_rd_q;
          end
          if (nxt_rd_q == '0) begin
            tail_d = prv_rd_q;
          end else begin
            prv_we = 1'b1; prv_wa = nxt_rd_q; prv_wd = prv_rd_q;
          end
          linked_d[cmd_q.pos] = 1'b0;
          if (fc_q < AW'(CAPACITY)) begin
            stk_we = 1'b1; stk_wa = fc_q; stk_wd = cmd_q.pos;
            fc_d   = fc_q + 1'b1;
          end
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          addr_d      = cmd_q.pos;
          value_d     = '0;
          state_d     = S_IDLE;
        end else begin
          after_d = a_sel;
          n_d     = stk_const_q ? (AW'(CAPACITY) - fc_m1) : stk_rd_q;
          if (a_sel == '0) begin
            r_d    = head_q;
            r_rd_d = 1'b0;
          end else begin
            nxt_re = 1'b1; nxt_ra = a_sel;
            r_rd_d = 1'b1;
          end
          state_d = S_B;
        end
      end
      S_B: begin
        r_d    = r_sel;
        val_we = 1'b1; val_wa = n_q; val_wd = cmd_q.val;
        nxt_we = 1'b1; nxt_wa = n_q; nxt_wd = r_sel;
        prv_we = 1'b1; prv_wa = n_q; prv_wd = after_q;
        linked_d[n_q] = 1'b1;
        state_d = S_C;
      end
      S_C: begin
        if (after_q == '0) begin
          head_d = n_q;
        end else begin
          nxt_we = 1'b1; nxt_wa = after_q; nxt_wd = n_q;
        end
        if (r_q == '0) begin
          tail_d = n_q;
        end else begin
          prv_we = 1'b1; prv_wa = r_q; prv_wd = n_q;
        end
        fc_d = fc_m1;
        if (fc_m1 < low_q) low_d = fc_m1;
        out_valid_d = 1'b1;
        status_d    = ST_OK;
        addr_d      = n_q;
        value_d     = '0;
        state_d     = S_IDLE;
      end
      S_FIND: begin
        if (val_rd_q == cmd_q.val) begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          addr_d      = n_q;
          value_d     = val_rd_q;
          state_d     = S_IDLE;
        end else if (nxt_rd_q == '0) begin
          out_valid_d = 1'b1;
          status_d    = ST_EMPTY;
          addr_d      = '0;
          value_d     = '0;
          state_d     = S_IDLE;
        end else begin
          n_d    = nxt_rd_q;
          nxt_re = 1'b1; nxt_ra = nxt_rd_q;
          val_re = 1'b1; val_ra = nxt_rd_q;
        end
      end
      S_Q1: begin
        if (n_sel == '0) begin
          out_valid_d = 1'b1;
          status_d    = ST_EMPTY;
          addr_d      = '0;
          value_d     = '0;
          state_d     = S_IDLE;
        end else begin
          n_d     = n_sel;
          val_re  = 1'b1;
          val_ra  = n_sel;
          state_d = S_Q2;
        end
      end
      S_Q2: begin
        out_valid_d = 1'b1;
        status_d    = ST_OK;
        addr_d      = n_q;
        value_d     = val_rd_q;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fc_q        <= AW'(CAPACITY);
      low_q       <= AW'(CAPACITY);
      linked_q    <= NODES'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fc_q        <= fc_d;
      low_q       <= low_d;
      linked_q    <= linked_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    after_q     <= after_d;
    r_q         <= r_d;
    n_q         <= n_d;
    after_rd_q  <= after_rd_d;
    r_rd_q      <= r_rd_d;
    n_rd_q      <= n_rd_d;
    stk_const_q <= stk_const_d;
    status_q    <= status_d;
    addr_q      <= addr_d;
    value_q     <= value_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign node_address_o = addr_q;
  assign node_value_o   = value_q;

endmodule

### sv/array_linked_list_manager.sv
// Top level of the array linked list manager.
// Input channel: in_valid_i / in_stall_o carry action_i, position_i and
// data_value_i; a transaction is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carry status_o, node_address_o
// and node_value_o, exactly one result per input transaction, in order.
// A two-entry command queue sits between the decoding front end and the
// executing back end, so input is taken while a result waits.
// Errors, clear and unused codes finish in S_CHK; remove goes through S_CHK
// and S_A, front/back/next/prev through S_CHK and S_Q1, then S_Q2 when a
// node is returned, and inserts through S_CHK, S_A, S_B and S_C.
// Find visits one list node per S_FIND step (up to 255), set by the
// single read port of the link and value tables.
// The back end executes one transaction at a time; the queue holds the rest.
// Reset empties the list, fills the free stack with 1..255 (1 on top) and
// needs no clearing pass; clear restores that state in one step.
// While out_stall_i is high the result holds and the back end waits; the
// queue absorbs two more transactions before in_stall_o rises.
module array_linked_list_manager
  import allm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [3:0]           action_i,
  input  logic [AW-1:0]        position_i,
  input  logic signed [DW-1:0] data_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [AW-1:0]        node_address_o,
  output logic signed [DW-1:0] node_value_o
);

  logic          cmd_valid, cmd_pop;
  cmd_t          cmd;
  logic [DW-1:0] value;

  allm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .position_i   (position_i),
    .data_value_i (data_value_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  allm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .node_address_o (node_address_o),
    .node_value_o   (value)
  );

  assign node_value_o = $signed(value);

endmodule

### sv/allm_checker.sv
// Port-level assertions for the array linked list manager and their bind.
module allm_checker
  import allm_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [3:0]           action_i,
  input logic [AW-1:0]        position_i,
  input logic signed [DW-1:0] data_value_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [2:0]           status_o,
  input logic [AW-1:0]        node_address_o,
  input logic signed [DW-1:0] node_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(node_address_o) && $stable(node_value_o))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_FULL ||
    status_o == ST_BADPOS || status_o == ST_UNLINKED || status_o == ST_EMPTY))
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> node_address_o == '0 && node_value_o == '0)
    else $error("failed result carries address or value");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(action_i) &&
    $stable(position_i) && $stable(data_value_i))
    else $error("stalled input transaction changed");

endmodule

bind array_linked_list_manager allm_checker u_allm_checker (.*);

### verif/tb_top.sv
// Self-checking testbench for the array linked list manager with a linked-list predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import allm_pkg::*;

  class list_scoreboard;
    logic [AW-1:0] next_link [NODES];
    logic [AW-1:0] prev_link [NODES];
    bit            linked [NODES];
    logic [DW-1:0] payload [NODES];
    logic [AW-1:0] free_nodes [CAPACITY];
    int            free_cnt;
    logic [2:0]    exp_status [$];
    logic [AW-1:0] exp_addr [$];
    logic [DW-1:0] exp_value [$];
    int            errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int k = 0; k < NODES; k++) begin
        next_link[k] = '0;
        prev_link[k] = '0;
        linked[k] = 0;
        payload[k] = '0;
      end
      linked[0] = 1;
      for (int k = 0; k < CAPACITY; k++) free_nodes[k] = AW'(CAPACITY - k);
      free_cnt = CAPACITY;
    endfunction

    function void push_exp(logic [2:0] s, logic [AW-1:0] a, logic [DW-1:0] v);
      exp_status.push_back(s);
      exp_addr.push_back(a);
      exp_value.push_back(v);
    endfunction

    function void link_new(logic [AW-1:0] after, logic [DW-1:0] v);
      logic [AW-1:0] n;
      logic [AW-1:0] r;
      if (free_cnt == 0) begin
        push_exp(ST_FULL, '0, '0);
        return;
      end
      free_cnt--;
      n = free_nodes[free_cnt];
      r = next_link[after];
      payload[n] = v;
      prev_link[n] = after;
      next_link[n] = r;
      linked[n] = 1;
      next_link[after] = n;
      prev_link[r] = n;
      push_exp(ST_OK, n, '0);
    endfunction

    function void report(logic [AW-1:0] n);
      if (n == 0) push_exp(ST_EMPTY, '0, '0);
      else push_exp(ST_OK, n, payload[n]);
    endfunction

    function void note_input(logic [3:0] act, logic [AW-1:0] pos, logic [DW-1:0] v);
      logic [AW-1:0] l;
      logic [AW-1:0] r;
      logic [AW-1:0] n;
      int steps;
      bit hit;
      case (act)
        ACT_PUSH_BACK: link_new(prev_link[0], v);
        ACT_PUSH_FRONT: link_new('0, v);
        ACT_INS_AFTER, ACT_INS_BEFORE: begin
          if (pos > CAPACITY) push_exp(ST_BADPOS, '0, '0);
          else if (!linked[pos]) push_exp(ST_UNLINKED, '0, '0);
          else link_new(act == ACT_INS_AFTER ? pos : prev_link[pos], v);
        end
        ACT_REMOVE: begin
          if (pos == 0 || pos > CAPACITY) push_exp(ST_BADPOS, '0, '0);
          else if (!linked[pos]) push_exp(ST_UNLINKED, '0, '0);
          else begin
            l = prev_link[pos];
            r = next_link[pos];
            next_link[l] = r;
            prev_link[r] = l;
            linked[pos] = 0;
            next_link[pos] = '0;
            prev_link[pos] = '0;
            if (free_cnt < CAPACITY) begin
              free_nodes[free_cnt] = pos;
              free_cnt++;
            end
            push_exp(ST_OK, pos, '0);
          end
        end
        ACT_FIND: begin
          n = next_link[0];
          steps = 0;
          hit = 0;
          while (n != 0 && steps < CAPACITY) begin
            if (payload[n] == v) begin
              hit = 1;
              break;
            end
            n = next_link[n];
            steps++;
          end
          if (hit) push_exp(ST_OK, n, payload[n]);
          else push_exp(ST_EMPTY, '0, '0);
        end
        ACT_FRONT: report(next_link[0]);
        ACT_BACK: report(prev_link[0]);
        ACT_NEXT, ACT_PREV: begin
          if (pos > CAPACITY) push_exp(ST_BADPOS, '0, '0);
          else if (!linked[pos]) push_exp(ST_UNLINKED, '0, '0);
          else report(act == ACT_NEXT ? next_link[pos] : prev_link[pos]);
        end
        ACT_CLEAR: begin
          wipe();
          push_exp(ST_OK, '0, '0);
        end
        default: push_exp(ST_OK, '0, '0);
      endcase
    endfunction

    function void check_result(logic [2:0] s, logic [AW-1:0] a, logic [DW-1:0] v);
      logic [2:0] es;
      logic [AW-1:0] ea;
      logic [DW-1:0] ev;
      if (exp_status.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%0d value=%h", $time, s, a, v);
        errors++;
        return;
      end
      es = exp_status.pop_front();
      ea = exp_addr.pop_front();
      ev = exp_value.pop_front();
      if (s !== es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, s);
        errors++;
      end
      if (a !== ea) begin
        $display("%0t: node_address expected %0d actual %0d", $time, ea, a);
        errors++;
      end
      if (v !== ev) begin
        $display("%0t: node_value expected %h actual %h", $time, ev, v);
        errors++;
      end
    endfunction

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 in_valid_i = 0;
  logic                 in_stall_o;
  logic [3:0]           action_i = '0;
  logic [AW-1:0]        position_i = '0;
  logic signed [DW-1:0] data_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 0;
  logic [2:0]           status_o;
  logic [AW-1:0]        node_address_o;
  logic signed [DW-1:0] node_value_o;

  list_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 1_500_000;

  array_linked_list_manager dut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("array_linked_list_manager test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, node_address_o, node_value_o);
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send(logic [3:0] act, logic [AW-1:0] pos, logic [DW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    action_i <= act;
    position_i <= pos;
    data_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(act, pos, v);
  endtask

  function automatic logic [AW-1:0] pick_pos();
    int r;
    r = $urandom_range(99);
    if (r < 70) return AW'($urandom_range(1, 20));
    if (r < 80) return '0;
    return AW'($urandom);
  endfunction

  task automatic random_item(int fill_bias);
    int r;
    logic [3:0] act;
    logic [DW-1:0] v;
    r = $urandom_range(99);
    v = ($urandom_range(3) == 0) ? $urandom : DW'($urandom_range(15));
    if (r < fill_bias) act = ($urandom_range(1)) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    else if (r < 97) act = 4'($urandom_range(ACT_INS_AFTER, ACT_PREV));
    else if (r < 99) act = ACT_CLEAR;
    else act = 4'($urandom_range(11, 15));
    send(act, pick_pos(), v);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send(ACT_FRONT, '0, '0);
    send(ACT_BACK, '0, '0);
    send(ACT_FIND, '0, '0);
    send(ACT_NEXT, '0, '0);
    send(ACT_PREV, 8'd255, '0);
    send(ACT_REMOVE, '0, '0);
    send(ACT_REMOVE, 8'd5, '0);
    send(ACT_INS_AFTER, 8'd7, 32'h1);
    send(ACT_PUSH_BACK, '0, 32'h8000_0000);
    send(ACT_PUSH_FRONT, '0, 32'h7FFF_FFFF);
    send(ACT_INS_AFTER, '0, 32'hFFFF_FFFF);
    send(ACT_INS_BEFORE, '0, 32'h0);
    send(ACT_INS_BEFORE, 8'd1, 32'h5A5A_A5A5);
    send(ACT_FIND, '0, 32'hFFFF_FFFF);
    send(ACT_FIND, '0, 32'h1234_5678);
    send(ACT_FRONT, '0, '0);
    send(ACT_BACK, '0, '0);
    send(ACT_NEXT, 8'd1, '0);
    send(ACT_PREV, 8'd2, '0);
    send(ACT_REMOVE, 8'd1, '0);
    send(ACT_NEXT, 8'd1, '0);
    send(4'd15, 8'hFF, 32'hFFFF_FFFF);
    send(4'd11, '0, '0);
    send(ACT_CLEAR, '0, '0);

    // fill the table to hit full, then probe it and clear it
    for (int k = 0; k < 257; k++) send(ACT_PUSH_BACK, '0, $urandom);
    send(ACT_INS_AFTER, 8'd255, 32'h3);
    send(ACT_FIND, '0, 32'hDEAD_BEEF);
    send(ACT_REMOVE, 8'd255, '0);
    send(ACT_CLEAR, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 75 : 0;
      recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 21 : 0;
      for (int k = 0; k < 350; k++) random_item(phase == 2 ? 25 : 40);
    end
    in_valid_i <= 0;
    recv_idle_pct = 0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0)
      $display("array_linked_list_manager test passed");
    else
      $display("array_linked_list_manager test failed");
    $finish;
  end
endmodule
